>>> sv/clnw_pkg.sv
// Shared types, constants and lookup functions for the character LCD nibble writer.
// No dependencies; imported by every module of the block.
package clnw_pkg;

  localparam int unsigned WaitW      = 20;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned ColW       = 5;
  localparam int unsigned LineWidthDef = 16;

  localparam logic [WaitW-1:0] PowerOnWaitRst = 20'd100000;
  localparam logic [WaitW-1:0] WakeWaitRst    = 20'd5000;
  localparam logic [WaitW-1:0] CommandWaitRst = 20'd5000;
  localparam logic [WaitW-1:0] DataWaitRst    = 20'd50;

  localparam logic [CfgIdxW-1:0] CfgPowerOn = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWake    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCommand = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgData    = 3'd3;

  localparam logic [1:0] CmdInit    = 2'd0;
  localparam logic [1:0] CmdCommand = 2'd1;
  localparam logic [1:0] CmdData    = 2'd2;
  localparam logic [1:0] CmdSetPos  = 2'd3;

  localparam logic [3:0] WakeNibble = 4'h3;
  localparam logic [3:0] FourBitNibble = 4'h2;
  localparam logic [7:0] SetDdramBase = 8'h80;

  // Event positions within the init run
  localparam logic [IdxW-1:0] InitPowerIdx = 4'd0;
  localparam logic [IdxW-1:0] InitRawLast  = 4'd4;
  localparam logic [IdxW-1:0] InitBytesBase = 4'd5;
  localparam logic [IdxW-1:0] InitLastIdx  = 4'd14;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [2:0] {
    WSEL_NONE,
    WSEL_POWER,
    WSEL_WAKE,
    WSEL_COMMAND,
    WSEL_DATA
  } wsel_e;

  // Item held by the sequencer while its run is sent
  typedef struct packed {
    logic            init;
    logic            rs;
    logic [7:0]      byte_val;
    logic [IdxW-1:0] idx;
  } job_t;

  // One event as decoded from the current job step
  typedef struct packed {
    logic       strobe;
    logic       rs;
    logic [3:0] nibble;
    wsel_e      wsel;
    logic       last;
  } evt_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h08;
      3'd2:    c = 8'h01;
      3'd3:    c = 8'h06;
      3'd4:    c = 8'h0E;
      default: c = 8'h0E;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] row_mask(input logic [1:0] r);
    logic [7:0] m;
    case (r)
      2'd0:    m = 8'h00;
      2'd1:    m = 8'h40;
      2'd2:    m = 8'h60;
      2'd3:    m = 8'h20;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> sv/clnw_evt.sv
// Event decoder: turns the sequencer's job and step index into one bus event.
// Depends on clnw_pkg.
module clnw_evt import clnw_pkg::*; (
  input  job_t job_i,
  output evt_t evt_o
);

  logic [IdxW-1:0] rel;
  logic [7:0]      init_byte;

  assign rel       = job_i.idx - InitBytesBase;
  assign init_byte = init_cmd(rel[3:1]);

  always_comb begin
    evt_o = '{strobe: 1'b1, rs: job_i.rs, nibble: 4'h0, wsel: WSEL_NONE, last: 1'b0};
    if (job_i.init) begin
      evt_o.rs = 1'b0;
      if (job_i.idx == InitPowerIdx) begin
        evt_o.strobe = 1'b0;
        evt_o.wsel   = WSEL_POWER;
      end else if (job_i.idx < InitRawLast) begin
        evt_o.nibble = WakeNibble;
        evt_o.wsel   = WSEL_WAKE;
      end else if (job_i.idx == InitRawLast) begin
        evt_o.nibble = FourBitNibble;
        evt_o.wsel   = WSEL_WAKE;
      end else if (!rel[0]) begin
        evt_o.nibble = init_byte[7:4];
      end else begin
        evt_o.nibble = init_byte[3:0];
        evt_o.wsel   = WSEL_COMMAND;
      end
      evt_o.last = (job_i.idx == InitLastIdx);
    end else begin
      // two-beat byte: high nibble without hold, then low nibble
      if (!job_i.idx[0]) begin
        evt_o.nibble = job_i.byte_val[7:4];
      end else begin
        evt_o.nibble = job_i.byte_val[3:0];
        evt_o.wsel   = job_i.rs ? WSEL_DATA : WSEL_COMMAND;
        evt_o.last   = 1'b1;
      end
    end
  end

endmodule

>>> sv/clnw_seq.sv
// Sequencer: takes one item, steps through its events and holds the output beat.
// Depends on clnw_pkg; event fields come from clnw_evt via the top level.
module clnw_seq import clnw_pkg::*; #(
  parameter int unsigned LINE_WIDTH = LineWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       byte_value_i,
  input  logic [ColW-1:0]  column_i,
  input  logic [1:0]       row_i,
  output job_t             job_o,
  input  evt_t             evt_i,
  input  logic [WaitW-1:0] wait_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             strobe_res_o,
  output logic             reg_select_o,
  output logic [3:0]       nibble_o,
  output logic [WaitW-1:0] wait_us_o,
  output logic             last_o
);

  localparam int unsigned CmpW = ColW + 2;
  localparam logic [CmpW-1:0] LineW = CmpW'(LINE_WIDTH);

  state_e state_q, state_d;
  job_t   job_q, job_d;
  logic   out_valid_q, out_valid_d;
  logic   load;
  logic   accept;
  logic   skip;
  logic   strobe_q, rs_q, last_q;
  logic [3:0]       nibble_q;
  logic [WaitW-1:0] wait_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign skip       = (cmd_i == CmdSetPos) && ({2'b00, column_i} >= LineW);
  assign load       = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept && !skip) begin
          job_d.idx  = '0;
          job_d.init = (cmd_i == CmdInit);
          job_d.rs   = (cmd_i == CmdData);
          if (cmd_i == CmdSetPos) begin
            job_d.byte_val = SetDdramBase | {3'b000, column_i} | row_mask(row_i);
          end else begin
            job_d.byte_val = byte_value_i;
          end
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (load) begin
          out_valid_d = 1'b1;
          job_d.idx   = job_q.idx + 1'b1;
          if (evt_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      job_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      job_q       <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      strobe_q <= evt_i.strobe;
      rs_q     <= evt_i.rs;
      nibble_q <= evt_i.nibble;
      wait_q   <= wait_i;
      last_q   <= evt_i.last;
    end
  end

  assign job_o        = job_q;
  assign out_valid_o  = out_valid_q;
  assign strobe_res_o = strobe_q;
  assign reg_select_o = rs_q;
  assign nibble_o     = nibble_q;
  assign wait_us_o    = wait_q;
  assign last_o       = last_q;

endmodule

>>> sv/char_lcd_nibble_writer_core.sv
// Character LCD 4-bit writer. An accepted item moves the sequencer into its run state; the
// sequencer then emits one event beat per cycle from its output register when not stalled.
// Init emits the power-on wait, the wake nibbles, the 4-bit nibble and the init bytes;
// command, data and set position send a byte as high then low nibble; a skipped one sends none.
// Reset (asynchronous, active low) idles the sequencer, empties the output register and
// loads the timing registers with their defaults.
module char_lcd_nibble_writer_core import clnw_pkg::*; #(
  parameter int unsigned LINE_WIDTH = LineWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WaitW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         byte_value_i,
  input  logic [ColW-1:0]    column_i,
  input  logic [1:0]         row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               strobe_res_o,
  output logic               reg_select_o,
  output logic [3:0]         nibble_o,
  output logic [WaitW-1:0]   wait_us_o,
  output logic               last_o
);

  logic [WaitW-1:0] power_on_wait_q, wake_wait_q, command_wait_q, data_wait_q;
  logic [WaitW-1:0] wait_sel;
  job_t job;
  evt_t evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_on_wait_q <= PowerOnWaitRst;
      wake_wait_q     <= WakeWaitRst;
      command_wait_q  <= CommandWaitRst;
      data_wait_q     <= DataWaitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPowerOn: power_on_wait_q <= cfg_wdata_i;
        CfgWake:    wake_wait_q     <= cfg_wdata_i;
        CfgCommand: command_wait_q  <= cfg_wdata_i;
        CfgData:    data_wait_q     <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  clnw_evt u_evt (
    .job_i (job),
    .evt_o (evt)
  );

  always_comb begin
    case (evt.wsel)
      WSEL_POWER:   wait_sel = power_on_wait_q;
      WSEL_WAKE:    wait_sel = wake_wait_q;
      WSEL_COMMAND: wait_sel = command_wait_q;
      WSEL_DATA:    wait_sel = data_wait_q;
      default:      wait_sel = '0;
    endcase
  end

  clnw_seq #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .byte_value_i (byte_value_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .job_o        (job),
    .evt_i        (evt),
    .wait_i       (wait_sel),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .strobe_res_o (strobe_res_o),
    .reg_select_o (reg_select_o),
    .nibble_o     (nibble_o),
    .wait_us_o    (wait_us_o),
    .last_o       (last_o)
  );

endmodule
